// ===== sv/fc_sigmoid_layer_jacobian_top_assert.svh =====
// Assertion macros used by the Jacobian layer top level.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef FC_SIGMOID_LAYER_JACOBIAN_TOP_ASSERT_SVH
`define FC_SIGMOID_LAYER_JACOBIAN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FCSJ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FCSJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FCSJ_ASSERT(lbl, clk, rstn, prop, msg)
`define FCSJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/fcsj_pkg.sv =====
// Types, constants and helper functions of the sigmoid layer Jacobian block.
// Used by every other file of the block but the assertion header; depends on nothing.
package fcsj_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int WADDR_W  = ROW_W + COL_W;
	localparam int CNT_W    = 5;
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = $clog2(Q_DEPTH);
	localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
	localparam int REGIDX_W = 3;

	typedef enum logic [1:0] {
		CMD_WEIGHT = 2'd0,
		CMD_BIAS   = 2'd1,
		CMD_INPUT  = 2'd2,
		CMD_REQ    = 2'd3
	} cmd_t;

	typedef enum logic [REGIDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_ROWS     = 3'd1,
		REG_COLS     = 3'd2,
		REG_CUT      = 3'd3,
		REG_FALLBACK = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_WEIGHT,
		K_BIAS,
		K_INPUT,
		K_REQ,
		K_ERR
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [15:0]       value;
	} op_t;

	typedef struct packed {
		logic              mode;
		logic [CNT_W-1:0]  rows;
		logic [CNT_W-1:0]  cols;
		logic [14:0]       cut;
		logic [15:0]       fallback;
	} cfg_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] cnt;
	} q_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MAC,
		B_EXP1,
		B_EXP2,
		B_EXP3,
		B_SQ,
		B_DINIT,
		B_DIV,
		B_RD,
		B_MUL,
		B_OUT,
		B_GOUT,
		B_ERR
	} bstate_t;

	// round(65536 * 2^(-k/16))
	function automatic logic [16:0] pow2_frac(input logic [4:0] k);
		logic [16:0] r;
		case (k)
			5'd0:    r = 17'd65536;
			5'd1:    r = 17'd62757;
			5'd2:    r = 17'd60097;
			5'd3:    r = 17'd57549;
			5'd4:    r = 17'd55109;
			5'd5:    r = 17'd52773;
			5'd6:    r = 17'd50535;
			5'd7:    r = 17'd48392;
			5'd8:    r = 17'd46341;
			5'd9:    r = 17'd44376;
			5'd10:   r = 17'd42495;
			5'd11:   r = 17'd40693;
			5'd12:   r = 17'd38968;
			5'd13:   r = 17'd37316;
			5'd14:   r = 17'd35734;
			5'd15:   r = 17'd34219;
			5'd16:   r = 17'd32768;
			default: r = 17'd32768;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] mx);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (v > mx)
			r = mx;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== sv/fcsj_if.sv =====
// Handshake channels of the Jacobian block: item input, result output, register writes.
// Depends on fcsj_pkg for field widths.
interface fcsj_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic [fcsj_pkg::ROW_W-1:0]  row;
	logic [fcsj_pkg::COL_W-1:0]  col;
	logic signed [15:0]          value;
	modport source(output valid, command, row, col, value, input ready);
	modport sink(input valid, command, row, col, value, output ready);
endinterface

interface fcsj_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [23:0]          entry;
	logic [4:0]                  entry_col;
	logic                        last;
	logic                        row_error;
	modport source(output valid, entry, entry_col, last, row_error, input ready);
	modport sink(input valid, entry, entry_col, last, row_error, output ready);
endinterface

interface fcsj_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fcsj_pkg::REGIDX_W-1:0]  index;
	logic [15:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/fcsj_front.sv =====
// Front end: takes input items, classifies them and hands them to the command queue.
// Depends on fcsj_pkg and fcsj_if.
module fcsj_front (
	input  logic                clk,
	input  logic                arst_n,
	fcsj_in_if.sink             items,
	input  fcsj_pkg::cfg_t      cfg,
	input  logic                q_full,
	output logic                q_push,
	output fcsj_pkg::op_t       q_item
);

	logic          valid_q;
	fcsj_pkg::op_t item_q;
	fcsj_pkg::op_t cls;

	assign items.ready = !valid_q || !q_full;
	assign q_push      = valid_q && !q_full;
	assign q_item      = item_q;

	always_comb begin
		cls.row   = items.row;
		cls.col   = items.col;
		cls.value = items.value;
		case (fcsj_pkg::cmd_t'(items.command))
			fcsj_pkg::CMD_WEIGHT: cls.kind = fcsj_pkg::K_WEIGHT;
			fcsj_pkg::CMD_BIAS:   cls.kind = fcsj_pkg::K_BIAS;
			fcsj_pkg::CMD_INPUT:  cls.kind = fcsj_pkg::K_INPUT;
			fcsj_pkg::CMD_REQ: begin
				if ({1'b0, items.row} >= cfg.rows)
					cls.kind = fcsj_pkg::K_ERR;
				else
					cls.kind = fcsj_pkg::K_REQ;
			end
			default: cls.kind = fcsj_pkg::K_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_q <= 1'b1;
		end else if (q_push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_q <= cls;
		end
	end

endmodule

// ===== sv/fcsj_fifo.sv =====
// Short command queue between the front end and the compute back end.
// Depends on fcsj_pkg.
module fcsj_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fcsj_pkg::op_t       push_item,
	input  logic                pop,
	output fcsj_pkg::op_t       head,
	output fcsj_pkg::q_stat_t   stat
);

	fcsj_pkg::op_t                    slot_q [fcsj_pkg::Q_DEPTH];
	logic [fcsj_pkg::QPTR_W-1:0]      wptr_q;
	logic [fcsj_pkg::QPTR_W-1:0]      rptr_q;
	logic [fcsj_pkg::QCNT_W-1:0]      cnt_q;

	assign head       = slot_q[rptr_q];
	assign stat.cnt   = cnt_q;
	assign stat.full  = cnt_q == fcsj_pkg::QCNT_W'(fcsj_pkg::Q_DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == fcsj_pkg::QPTR_W'(fcsj_pkg::Q_DEPTH - 1)) ? '0
					: wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == fcsj_pkg::QPTR_W'(fcsj_pkg::Q_DEPTH - 1)) ? '0
					: rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_item;
	end

endmodule

// ===== sv/fcsj_back.sv =====
// Back end: owns the weight, bias and input stores, runs the row dot product,
// the exp approximation, the derivative divide and the result emission.
// Depends on fcsj_pkg and fcsj_if.
module fcsj_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fcsj_pkg::cfg_t      cfg,
	input  fcsj_pkg::op_t       head,
	input  logic                q_empty,
	output logic                q_pop,
	fcsj_out_if.source          results
);

	localparam int WDEPTH = fcsj_pkg::MAX_ROWS * fcsj_pkg::MAX_COLS;

	fcsj_pkg::bstate_t state_q, state_d;

	logic [15:0] wmem [WDEPTH];
	logic [15:0] wrd_q;
	logic        wmem_we, wmem_re;
	logic [fcsj_pkg::WADDR_W-1:0] raddr;

	logic signed [15:0] bias_q [fcsj_pkg::MAX_ROWS];
	logic signed [15:0] inp_q  [fcsj_pkg::MAX_COLS];

	logic [fcsj_pkg::ROW_W-1:0] row_q;
	logic [fcsj_pkg::CNT_W-1:0] j_q;
	logic                       v1_s1, v2_s2;
	logic signed [15:0]         xin_s1;
	logic signed [31:0]         prod_s2;
	logic signed [35:0]         acc_q;
	logic                       cut_q;
	logic [36:0]                t_q;
	logic [23:0]                dprod_q;
	logic [16:0]                e_q;
	logic [35:0]                dd_q;
	logic [51:0]                rem_q;
	logic [3:0]                 cnt_q;
	logic [15:0]                g_q;
	logic signed [32:0]         eprod_q;

	logic                       out_valid_q;
	logic signed [23:0]         out_entry_q;
	logic [4:0]                 out_col_q;
	logic                       out_last_q;
	logic                       out_err_q;
	logic                       out_free;
	logic                       out_load;

	logic                       mac_busy;
	logic signed [35:0]         cut_neg;
	logic [34:0]                mag;
	logic [52:0]                tprod;
	logic [4:0]                 fk;
	logic [16:0]                tk, tk1;
	logic [12:0]                corr;
	logic [16:0]                pval;
	logic [4:0]                 nsh;
	logic [17:0]                half, esum;
	logic [17:0]                sq_in;
	logic [51:0]                dsh;
	logic signed [15:0]         mult;
	logic signed [24:0]         scaled;
	logic signed [23:0]         sat;

	assign out_free          = !out_valid_q || results.ready;
	assign out_load          = out_free && (state_q inside {fcsj_pkg::B_OUT,
		fcsj_pkg::B_GOUT, fcsj_pkg::B_ERR});
	assign results.valid     = out_valid_q;
	assign results.entry     = out_entry_q;
	assign results.entry_col = out_col_q;
	assign results.last      = out_last_q;
	assign results.row_error = out_err_q;

	// Datapath terms
	always_comb begin
		mac_busy = (j_q < cfg.cols) || v1_s1 || v2_s2;
		cut_neg  = -$signed(36'({cfg.cut, 8'h00}));
		mag      = acc_q[35] ? 35'(-acc_q) : acc_q[34:0];
		tprod    = {18'b0, mag} * 53'd94548;
		fk       = {1'b0, t_q[15:12]};
		tk       = fcsj_pkg::pow2_frac(fk);
		tk1      = fcsj_pkg::pow2_frac(fk + 5'd1);
		corr     = 13'((25'(dprod_q) + 25'd2048) >> 12);
		pval     = tk - {4'b0, corr};
		nsh      = t_q[20:16];
		half     = (18'd1 << nsh) >> 1;
		esum     = (18'(pval) + half) >> nsh;
		sq_in    = 18'(e_q) + 18'd65536;
		dsh      = 52'(dd_q) << cnt_q;
		mult     = cfg.mode ? xin_s1 : $signed(wrd_q);
		scaled   = 25'((eprod_q + 33'sd128) >>> 8);
		if (scaled > 25'sd8388607)
			sat = 24'sd8388607;
		else if (scaled < -25'sd8388608)
			sat = -24'sd8388608;
		else
			sat = scaled[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fcsj_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		wmem_we = 1'b0;
		wmem_re = 1'b0;
		raddr   = {row_q, j_q[fcsj_pkg::COL_W-1:0]};
		case (state_q)
			fcsj_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (head.kind)
						fcsj_pkg::K_WEIGHT: wmem_we = 1'b1;
						fcsj_pkg::K_REQ:    state_d = fcsj_pkg::B_MAC;
						fcsj_pkg::K_ERR:    state_d = fcsj_pkg::B_ERR;
						default:            state_d = fcsj_pkg::B_IDLE;
					endcase
				end
			end
			fcsj_pkg::B_MAC: begin
				wmem_re = j_q < cfg.cols;
				if (!mac_busy)
					state_d = fcsj_pkg::B_EXP1;
			end
			fcsj_pkg::B_EXP1:  state_d = fcsj_pkg::B_EXP2;
			fcsj_pkg::B_EXP2:  state_d = fcsj_pkg::B_EXP3;
			fcsj_pkg::B_EXP3:  state_d = fcsj_pkg::B_SQ;
			fcsj_pkg::B_SQ:    state_d = fcsj_pkg::B_DINIT;
			fcsj_pkg::B_DINIT: state_d = fcsj_pkg::B_DIV;
			fcsj_pkg::B_DIV: begin
				if (cnt_q == '0)
					state_d = fcsj_pkg::B_RD;
			end
			fcsj_pkg::B_RD: begin
				wmem_re = 1'b1;
				state_d = fcsj_pkg::B_MUL;
			end
			fcsj_pkg::B_MUL: state_d = fcsj_pkg::B_OUT;
			fcsj_pkg::B_OUT: begin
				if (out_free) begin
					if (j_q + 1'b1 < cfg.cols)
						state_d = fcsj_pkg::B_RD;
					else if (cfg.mode)
						state_d = fcsj_pkg::B_GOUT;
					else
						state_d = fcsj_pkg::B_IDLE;
				end
			end
			fcsj_pkg::B_GOUT, fcsj_pkg::B_ERR: begin
				if (out_free)
					state_d = fcsj_pkg::B_IDLE;
			end
			default: state_d = fcsj_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wmem_we)
			wmem[{head.row, head.col}] <= head.value;
		if (wmem_re)
			wrd_q <= wmem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				fcsj_pkg::B_IDLE: begin
					j_q   <= '0;
					v1_s1 <= 1'b0;
					v2_s2 <= 1'b0;
				end
				fcsj_pkg::B_MAC: begin
					v1_s1 <= j_q < cfg.cols;
					v2_s2 <= v1_s1;
					if (j_q < cfg.cols)
						j_q <= j_q + 1'b1;
				end
				fcsj_pkg::B_DINIT: j_q <= '0;
				fcsj_pkg::B_OUT: begin
					if (out_free)
						j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fcsj_pkg::B_IDLE: begin
				if (!q_empty) begin
					row_q <= head.row;
					acc_q <= 36'(bias_q[head.row]) <<< 8;
					case (head.kind)
						fcsj_pkg::K_BIAS:  bias_q[head.row] <= head.value;
						fcsj_pkg::K_INPUT: inp_q[head.col]  <= head.value;
						default: ;
					endcase
				end
			end
			fcsj_pkg::B_MAC: begin
				xin_s1  <= inp_q[j_q[fcsj_pkg::COL_W-1:0]];
				prod_s2 <= $signed(wrd_q) * xin_s1;
				if (v2_s2)
					acc_q <= acc_q + 36'(prod_s2);
			end
			fcsj_pkg::B_EXP1: begin
				cut_q <= acc_q <= cut_neg;
				t_q   <= tprod[52:16];
			end
			fcsj_pkg::B_EXP2: dprod_q <= 24'(tk - tk1) * {12'b0, t_q[11:0]};
			fcsj_pkg::B_EXP3: begin
				if (cut_q)
					e_q <= {1'b0, cfg.fallback};
				else if (t_q[36:16] >= 21'd17)
					e_q <= '0;
				else
					e_q <= esum[16:0];
			end
			fcsj_pkg::B_SQ: dd_q <= sq_in * sq_in;
			fcsj_pkg::B_DINIT: begin
				rem_q <= (52'(e_q) << 32) + 52'(dd_q >> 1);
				cnt_q <= 4'd15;
				g_q   <= '0;
			end
			fcsj_pkg::B_DIV: begin
				if (rem_q >= dsh) begin
					rem_q        <= rem_q - dsh;
					g_q[cnt_q]   <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			fcsj_pkg::B_RD: xin_s1 <= inp_q[j_q[fcsj_pkg::COL_W-1:0]];
			fcsj_pkg::B_MUL: eprod_q <= mult * $signed({1'b0, g_q});
			fcsj_pkg::B_OUT: begin
				if (out_free) begin
					out_entry_q <= sat;
					out_col_q   <= j_q;
					out_last_q  <= !cfg.mode && (j_q + 1'b1 == cfg.cols);
					out_err_q   <= 1'b0;
				end
			end
			fcsj_pkg::B_GOUT: begin
				if (out_free) begin
					out_entry_q <= $signed({8'b0, g_q});
					out_col_q   <= cfg.cols;
					out_last_q  <= 1'b1;
					out_err_q   <= 1'b0;
				end
			end
			fcsj_pkg::B_ERR: begin
				if (out_free) begin
					out_entry_q <= '0;
					out_col_q   <= '0;
					out_last_q  <= 1'b1;
					out_err_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/fc_sigmoid_layer_jacobian_top.sv =====
// Top level of the fully connected sigmoid layer Jacobian block.
// Depends on fcsj_pkg, fcsj_if, fcsj_front, fcsj_fifo, fcsj_back and the assertion header.
`include "fc_sigmoid_layer_jacobian_top_assert.svh"

// Weight, bias and input writes are stored by the back end one per cycle while
// it is idle. A row request runs through a single back end sequencer: the
// multiply-accumulate over the weight memory port, the exp approximation, a
// squaring step, a bit-serial divide, then a read, a multiply and a load of
// the output register for each emitted entry, plus a bias entry in weight mode.
// An out-of-range row goes straight to an error result. The front end and a
// two-entry queue keep accepting items while the back end is busy, until both
// are full, and a finished result waits in the output register without holding
// the front back. Register writes are registered and accepted in every cycle.
module fc_sigmoid_layer_jacobian_top (
	input  logic        clk,
	input  logic        arst_n,
	fcsj_in_if.sink     items,
	fcsj_out_if.source  results,
	fcsj_cfg_if.sink    cfg
);

	fcsj_pkg::cfg_t     cfg_q;
	fcsj_pkg::op_t      push_item, head;
	fcsj_pkg::q_stat_t  q_stat;
	logic               q_push, q_pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= 1'b0;
			cfg_q.rows     <= fcsj_pkg::CNT_W'(fcsj_pkg::MAX_ROWS);
			cfg_q.cols     <= fcsj_pkg::CNT_W'(fcsj_pkg::MAX_COLS);
			cfg_q.cut      <= 15'd5120;
			cfg_q.fallback <= 16'd1;
		end else if (cfg.valid) begin
			case (fcsj_pkg::reg_idx_t'(cfg.index))
				fcsj_pkg::REG_MODE: cfg_q.mode <= cfg.data[0];
				fcsj_pkg::REG_ROWS: cfg_q.rows <= fcsj_pkg::clamp_cnt(cfg.data[4:0],
					fcsj_pkg::CNT_W'(fcsj_pkg::MAX_ROWS));
				fcsj_pkg::REG_COLS: cfg_q.cols <= fcsj_pkg::clamp_cnt(cfg.data[4:0],
					fcsj_pkg::CNT_W'(fcsj_pkg::MAX_COLS));
				fcsj_pkg::REG_CUT:      cfg_q.cut      <= cfg.data[14:0];
				fcsj_pkg::REG_FALLBACK: cfg_q.fallback <= cfg.data;
				default: ;
			endcase
		end
	end

	fcsj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg_q),
		.q_full    (q_stat.full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	fcsj_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head),
		.stat      (q_stat)
	);

	fcsj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_empty   (q_stat.empty),
		.q_pop     (q_pop),
		.results   (results)
	);

	`FCSJ_ASSERT(a_no_overflow, clk, arst_n, q_push |-> !q_stat.full, "queue push while full")
	`FCSJ_ASSERT(a_no_underflow, clk, arst_n, q_pop |-> !q_stat.empty, "queue pop while empty")
	`FCSJ_ASSERT(a_err_shape, clk, arst_n, (results.valid && results.row_error) |-> (results.last && results.entry == 24'sd0), "row error result malformed")
	`FCSJ_ASSERT_NEXT(a_drain, clk, arst_n, q_pop && !q_push && q_stat.cnt == 2'd1, q_stat.empty, "queue did not drain")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fully connected sigmoid layer Jacobian block.
// Depends on fcsj_pkg and the channel interfaces in fcsj_if; predicts every
// result in a scoreboard class and drives the block through plain tasks.
`timescale 1ns / 100ps

module tb_top;
	import fcsj_pkg::*;

	localparam reg_idx_t REG_SPARE = reg_idx_t'(3'd5);

	typedef struct {
		logic signed [23:0] entry;
		logic [4:0]         col;
		logic               last;
		logic               err;
	} jac_entry_t;

	class jacobian_scoreboard;
		shortint     weights[MAX_ROWS*MAX_COLS];
		shortint     biases[MAX_ROWS];
		shortint     inputs[MAX_COLS];
		bit          mode;
		int unsigned rows_reg, cols_reg, cut_reg, fallback_reg;
		jac_entry_t  pending_entries[$];
		int          errors;
		int unsigned pow2_lut[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
			48392, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

		function new();
			mode = 0;
			rows_reg = 16;
			cols_reg = 16;
			cut_reg = 5120;
			fallback_reg = 1;
			errors = 0;
		endfunction

		function int unsigned rows_active();
			return rows_reg == 0 ? 1 : (rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg);
		endfunction

		function int unsigned cols_active();
			return cols_reg == 0 ? 1 : (cols_reg > MAX_COLS ? MAX_COLS : cols_reg);
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] data);
			case (idx)
				REG_MODE:     mode = data[0];
				REG_ROWS:     rows_reg = data[4:0];
				REG_COLS:     cols_reg = data[4:0];
				REG_CUT:      cut_reg = data[14:0];
				REG_FALLBACK: fallback_reg = data;
				default: ;
			endcase
		endfunction

		// exp(-a) for a in Q16.16, result Q1.16, via 2^-x with a 16-step table.
		function longint unsigned exp_neg(longint unsigned a);
			longint unsigned t, n, f, k, lo, p;
			t = (a * 94548) >> 16;
			n = t >> 16;
			f = t & 64'hFFFF;
			k = f >> 12;
			lo = f & 64'hFFF;
			if (n >= 17)
				return 0;
			p = pow2_lut[k] - (((pow2_lut[k] - pow2_lut[k+1]) * lo + 2048) >> 12);
			return (p + ((64'd1 << n) >> 1)) >> n;
		endfunction

		function logic signed [23:0] scaled(longint v);
			longint r;
			r = (v + 128) >>> 8;
			if (r > 8388607)
				r = 8388607;
			if (r < -8388608)
				r = -8388608;
			return r[23:0];
		endfunction

		function void predict_row(int unsigned r);
			longint          z, m;
			longint unsigned e, d, g;
			int unsigned     nc;
			jac_entry_t      x;
			nc = cols_active();
			if (r >= rows_active()) begin
				x = '{entry: 0, col: 0, last: 1, err: 1};
				pending_entries.push_back(x);
				return;
			end
			z = 0;
			for (int j = 0; j < nc; j++)
				z += longint'(weights[r*MAX_COLS+j]) * longint'(inputs[j]);
			z += longint'(biases[r]) * 256;
			if (z <= -(longint'(cut_reg) * 256))
				e = fallback_reg;
			else
				e = exp_neg(z < 0 ? -z : z);
			d = (65536 + e) * (65536 + e);
			g = ((e << 32) + (d >> 1)) / d;
			for (int j = 0; j < nc; j++) begin
				m = mode ? longint'(inputs[j]) : longint'(weights[r*MAX_COLS+j]);
				x.entry = scaled(m * longint'(g));
				x.col = j;
				x.last = !mode && (j + 1 == nc);
				x.err = 0;
				pending_entries.push_back(x);
			end
			if (mode) begin
				x = '{entry: g[23:0], col: nc[4:0], last: 1, err: 0};
				pending_entries.push_back(x);
			end
		endfunction

		function void note_item(cmd_t c, logic [3:0] r, logic [3:0] cl, logic [15:0] v);
			case (c)
				CMD_WEIGHT: weights[{r, cl}] = v;
				CMD_BIAS:   biases[r] = v;
				CMD_INPUT:  inputs[cl] = v;
				CMD_REQ:    predict_row(r);
			endcase
		endfunction

		task report(string what);
			$display("%0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic signed [23:0] entry, logic [4:0] col, logic last,
			logic err);
			jac_entry_t x;
			if (pending_entries.size() == 0) begin
				report($sformatf("unexpected result entry=%0d col=%0d", entry, col));
				return;
			end
			x = pending_entries.pop_front();
			if (entry !== x.entry)
				report($sformatf("entry %0d, predicted %0d", entry, x.entry));
			if (col !== x.col)
				report($sformatf("entry_col %0d, predicted %0d", col, x.col));
			if (last !== x.last)
				report($sformatf("last %b, predicted %b", last, x.last));
			if (err !== x.err)
				report($sformatf("row_error %b, predicted %b", err, x.err));
		endtask
	endclass

	logic clk;
	logic arst_n;
	fcsj_in_if  items_ch();
	fcsj_out_if results_ch();
	fcsj_cfg_if cfg_ch();

	fc_sigmoid_layer_jacobian_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	jacobian_scoreboard sb = new();
	int  send_idle_pct = 25;
	int  take_idle_pct = 25;
	bit  weight_written[MAX_ROWS*MAX_COLS];
	bit  bias_written[MAX_ROWS];
	bit  input_written[MAX_COLS];
	int  item_count;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(negedge clk) begin
		results_ch.ready = ($urandom_range(99) >= take_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.entry, results_ch.entry_col, results_ch.last,
				results_ch.row_error);
	end

	function logic [15:0] rand_value();
		if ($urandom_range(1))
			return $urandom_range(16'hFFFF);
		return 16'($urandom_range(1023)) - 16'd512;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task put_item(cmd_t c, logic [3:0] r, logic [3:0] cl, logic [15:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			items_ch.valid = 0;
			@(negedge clk);
		end
		items_ch.valid = 1;
		items_ch.command = c;
		items_ch.row = r;
		items_ch.col = cl;
		items_ch.value = v;
		do @(posedge clk); while (!items_ch.ready);
		sb.note_item(c, r, cl, v);
		case (c)
			CMD_WEIGHT: weight_written[{r, cl}] = 1;
			CMD_BIAS:   bias_written[r] = 1;
			CMD_INPUT:  input_written[cl] = 1;
			default: ;
		endcase
		item_count++;
		@(negedge clk);
	endtask

	// A request only reads entries that have been loaded, so fill any gaps first.
	task request_row(logic [3:0] r);
		if (r < sb.rows_active()) begin
			for (int j = 0; j < sb.cols_active(); j++) begin
				if (!weight_written[{r, 4'(j)}])
					put_item(CMD_WEIGHT, r, j, rand_value());
				if (!input_written[j])
					put_item(CMD_INPUT, $urandom_range(15), j, rand_value());
			end
			if (!bias_written[r])
				put_item(CMD_BIAS, r, $urandom_range(15), rand_value());
		end
		put_item(CMD_REQ, r, $urandom_range(15), rand_value());
	endtask

	task write_reg(reg_idx_t idx, logic [15:0] data);
		cfg_ch.valid = 1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 0;
	endtask

	// Wait until every predicted result has arrived and the back end has gone quiet.
	task drain();
		items_ch.valid = 0;
		while (sb.pending_entries.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	initial begin
		int rows_pick[5] = '{16, 1, 0, 31, 4};
		int cols_pick[5] = '{1, 16, 0, 31, 3};
		int cut_pick[4] = '{32767, 0, 5120, 1500};
		int fb_pick[4] = '{65535, 0, 1, 30000};
		int quota;
		cmd_t c;

		arst_n = 0;
		items_ch.valid = 0;
		items_ch.command = CMD_WEIGHT;
		items_ch.row = 0;
		items_ch.col = 0;
		items_ch.value = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_MODE;
		cfg_ch.data = 0;
		results_ch.ready = 0;
		item_count = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extreme products, the cutoff, the far exp tail, an idle row and out-of-range rows.
		write_reg(REG_COLS, 2);
		put_item(CMD_WEIGHT, 0, 0, 16'h7FFF);
		put_item(CMD_WEIGHT, 0, 1, 16'h8000);
		put_item(CMD_INPUT, 0, 0, 16'h8000);
		put_item(CMD_INPUT, 15, 1, 16'h7FFF);
		put_item(CMD_BIAS, 0, 0, 16'h0000);
		put_item(CMD_REQ, 0, 0, 0);
		put_item(CMD_INPUT, 0, 0, 16'h0100);
		put_item(CMD_INPUT, 0, 1, 16'h0000);
		put_item(CMD_REQ, 0, 15, 16'hFFFF);
		put_item(CMD_BIAS, 0, 0, 16'h0000);
		put_item(CMD_WEIGHT, 0, 0, 16'h0000);
		put_item(CMD_REQ, 0, 0, 0);
		put_item(CMD_WEIGHT, 15, 15, 16'h7FFF);
		put_item(CMD_WEIGHT, 15, 0, 16'hFFFF);
		put_item(CMD_WEIGHT, 15, 1, 16'h0001);
		put_item(CMD_BIAS, 15, 15, 16'h8000);
		put_item(CMD_REQ, 15, 0, 0);
		drain();
		write_reg(REG_MODE, 1);
		write_reg(REG_ROWS, 1);
		put_item(CMD_REQ, 0, 0, 0);
		put_item(CMD_REQ, 15, 0, 0);
		put_item(CMD_REQ, 1, 0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(REG_MODE, p[0] ? 16'hFFFE : 16'h0001 ^ 16'(p[0]));
			write_reg(REG_ROWS, p < 5 ? rows_pick[p] : $urandom_range(16'hFFFF));
			write_reg(REG_COLS, p < 5 ? cols_pick[p] : $urandom_range(16));
			write_reg(REG_CUT, p < 4 ? cut_pick[p] : $urandom_range(16'hFFFF));
			write_reg(REG_FALLBACK, p < 4 ? fb_pick[p] : $urandom_range(16'hFFFF));
			if (p == 2)
				write_reg(REG_SPARE, $urandom_range(16'hFFFF));
			send_idle_pct = (p == 3) ? 0 : 25;
			take_idle_pct = (p == 3) ? 0 : 25;
			quota = item_count + 44;
			while (item_count < quota) begin
				if ($urandom_range(99) < 75)
					request_row($urandom_range(15));
				else begin
					c = cmd_t'($urandom_range(2));
					put_item(c, $urandom_range(15), $urandom_range(15), rand_value());
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_entries.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
